/* design/i2crf_pkg.sv */
// Shared types and constants for the I2C register file slave core.
// Used by the controller, the datapath and the top level; no dependencies.
package i2crf_pkg;

  // Register file geometry
  localparam int unsigned RegDepth = 256;
  localparam int unsigned AddrW    = $clog2(RegDepth);
  localparam int unsigned DataW    = 8;

  // Special register addresses
  localparam logic [AddrW-1:0] RegRevision = 8'h00;
  localparam logic [AddrW-1:0] RegIrqA     = 8'h96;
  localparam logic [AddrW-1:0] RegIrqB     = 8'h97;
  localparam logic [AddrW-1:0] RegSigA     = 8'hC5;
  localparam logic [AddrW-1:0] RegSigB     = 8'hC6;

  // Signal state bits
  localparam logic [DataW-1:0] SigHotplug = 8'h40;
  localparam logic [DataW-1:0] SigSense   = 8'h20;

  // Bus event kinds
  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_OTHER = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_READ  = 2'd3
  } action_e;

  // Controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;  // take the input transaction, issue the RAM read
    logic finish;  // commit state updates and load the result
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic slot_free;  // output register can take a result this cycle
  } ctrl_sts_t;

endpackage

/* design/i2crf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module i2crf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/i2crf_ctrl.sv */
// Controller state machine for the I2C register file slave core.
// Depends on i2crf_pkg for the state enum and command/status structs.
module i2crf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  i2crf_pkg::ctrl_sts_t sts_i,
  output i2crf_pkg::ctrl_cmd_t cmd_o
);
  import i2crf_pkg::*;

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_EXEC: begin
        cmd_o.finish = sts_i.slot_free;
      end
      default: ;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* design/i2crf_dpath.sv */
// Datapath for the I2C register file slave core: item latch, pointer,
// valid bits, register file RAM and output register. Depends on i2crf_pkg
// and i2crf_ram.
module i2crf_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  i2crf_pkg::ctrl_cmd_t          cmd_i,
  output i2crf_pkg::ctrl_sts_t          sts_o,
  input  logic [1:0]                    action_i,
  input  logic [i2crf_pkg::DataW-1:0]   data_i,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [i2crf_pkg::DataW-1:0]   read_data_o
);
  import i2crf_pkg::*;

  action_e              act_q;
  logic [DataW-1:0]     data_q;
  logic [AddrW-1:0]     ptr_q, ptr_d;
  logic                 loaded_q, loaded_d;
  logic                 sink_q;
  logic [RegDepth-1:0]  valid_q, valid_d;
  logic                 out_valid_q, out_valid_d;
  logic [DataW-1:0]     out_data_q, out_data_d;

  logic                 ram_we;
  logic [DataW-1:0]     ram_wdata;
  logic [DataW-1:0]     ram_rdata;
  logic [DataW-1:0]     stored;
  logic [DataW-1:0]     result;
  logic [AddrW-1:0]     ptr_inc;

  // Register file storage; read at the pointer when a transaction is taken
  i2crf_ram #(
    .Width (DataW),
    .Depth (RegDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ptr_q),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.accept),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  // Never-written entries read as their reset value of zero
  assign stored  = valid_q[ptr_q] ? ram_rdata : '0;
  assign ptr_inc = AddrW'(ptr_q + 1'b1);

  // Execute the latched transaction
  always_comb begin
    ptr_d     = ptr_q;
    loaded_d  = loaded_q;
    ram_we    = 1'b0;
    ram_wdata = data_q;
    result    = '0;
    if (cmd_i.finish) begin
      unique case (act_q)
        ACT_START: loaded_d = 1'b0;
        ACT_OTHER: ;
        ACT_WRITE: begin
          if (!loaded_q) begin
            ptr_d    = data_q;
            loaded_d = 1'b1;
          end else begin
            ptr_d = ptr_inc;
            priority if (ptr_q == RegRevision || ptr_q == RegSigA || ptr_q == RegSigB) begin
              ram_we = 1'b0;
            end else if (ptr_q == RegIrqA || ptr_q == RegIrqB) begin
              // Write-1-to-clear
              ram_we    = 1'b1;
              ram_wdata = stored & ~data_q;
            end else begin
              ram_we = 1'b1;
            end
          end
        end
        ACT_READ: begin
          ptr_d = ptr_inc;
          if (ptr_q == RegSigA) begin
            result = sink_q ? (SigHotplug | SigSense) : '0;
          end else begin
            result = stored;
          end
        end
        default: ;
      endcase
    end
  end

  // Mark written entries
  always_comb begin
    valid_d = valid_q;
    if (ram_we) begin
      valid_d[ptr_q] = 1'b1;
    end
  end

  // Output register: load on finish, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
      out_data_d  = result;
    end
  end

  assign sts_o.slot_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign read_data_o     = out_data_q;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      loaded_q    <= 1'b0;
      sink_q      <= 1'b0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ptr_q       <= ptr_d;
      loaded_q    <= loaded_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        sink_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (cmd_i.accept) begin
      act_q  <= action_e'(action_i);
      data_q <= data_i;
    end
  end

endmodule

/* design/i2c_register_file_slave_core.sv */
// Top level of the I2C register file slave core.
// Depends on i2crf_pkg, i2crf_ctrl, i2crf_dpath and i2crf_ram.
//
// Byte-level programming port of an I2C slave: a 256-byte register file
// with an auto-incrementing pointer. tuser carries the bus event kind
// (start of write, other event, write byte, read byte) and tdata the written
// byte; every input transaction yields one output transaction whose tdata is
// the byte read, or zero for non-read events. Each transaction is first
// accepted, with the register file RAM read at the pointer, and then
// executed: the write (including write-1-to-clear) is applied and the result
// loaded, since the RAM read data is registered. A result that is not taken
// holds the block in its execute state until the output register frees up. The
// register file needs no clearing pass after reset: per-entry valid bits,
// cleared by reset, make never-written entries read as zero.
module i2c_register_file_slave_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration: bit 0 = sink_connected
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  // Input stream
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data
  input  logic [1:0] s_axis_tuser_i,   // [1:0] action
  // Output stream
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // [7:0] read_data
);
  import i2crf_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Sequencer
  i2crf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Pointer, register file and output register
  i2crf_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .action_i    (s_axis_tuser_i),
    .data_i      (s_axis_tdata_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .read_data_o (m_axis_tdata_o)
  );

`ifndef NO_ASSERTIONS
  // A taken transaction keeps the input closed for its execute cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept |=> !s_axis_tready_o)
    else $error("input ready right after accepting a transaction");

  // Finishing a transaction presents a result next cycle
  a_result_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> m_axis_tvalid_o)
    else $error("no result after finishing a transaction");

  // Accept and finish never coincide
  a_accept_finish_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.accept && cmd.finish))
    else $error("accept and finish in the same cycle");

  // Finish only when the output register can take the result
  a_finish_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("result would overwrite an untaken result");
`endif

endmodule
